/* rtl/lnu_pkg.sv */
// Shared types, constants and fixed-point helpers for the LIF neuron update block.
package lnu_pkg;

    localparam int NEURON_COUNT_DEF = 1024;
    localparam int IDX_W            = 10;
    localparam int Q_W              = 32;
    localparam int PROD_W           = 2 * Q_W;
    localparam int CNT_W            = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int FRAC_W           = 16;

    localparam logic signed [Q_W-1:0] Q_MAX       = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN       = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] DECAY_RESET = Q_W'(32'sh0001_0000);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY_COEF  = 3'd0,
        REG_INPUT_COEF  = 3'd1,
        REG_BIAS        = 3'd2,
        REG_NOISE_GAIN  = 3'd3,
        REG_THRESHOLD   = 3'd4,
        REG_RESET_VOLT  = 3'd5,
        REG_REFRACT     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [Q_W-1:0] decay_coefficient;
        logic signed [Q_W-1:0] input_coefficient;
        logic signed [Q_W-1:0] bias_current;
        logic signed [Q_W-1:0] noise_gain;
        logic signed [Q_W-1:0] fire_threshold;
        logic signed [Q_W-1:0] reset_voltage;
        logic [CNT_W-1:0]      refractory_steps;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]      idx;
        logic                  ok;
        logic                  refr;
        logic                  fire;
        logic                  integ;
        logic signed [Q_W-1:0] fix_v;
        logic [CNT_W-1:0]      ncnt;
    } stage_ctl_t;

    function automatic logic signed [Q_W-1:0] sat_add(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        logic [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
        begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return s[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = (p + ROUND_HALF) >>> FRAC_W;
        if (t > PROD_W'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (t < PROD_W'(Q_MIN))
        begin
            return Q_MIN;
        end
        return t[Q_W-1:0];
    endfunction

endpackage

/* rtl/lnu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lnu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lnu_cfg_regs.sv */
// Configuration register file for the shared neuron parameters.
module lnu_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lnu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lnu_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lnu_pkg::cfg_t                    cfg
);

    import lnu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DECAY_COEF: cfg_next.decay_coefficient = cfg_data[Q_W-1:0];
                REG_INPUT_COEF: cfg_next.input_coefficient = cfg_data[Q_W-1:0];
                REG_BIAS:       cfg_next.bias_current      = cfg_data[Q_W-1:0];
                REG_NOISE_GAIN: cfg_next.noise_gain        = cfg_data[Q_W-1:0];
                REG_THRESHOLD:  cfg_next.fire_threshold    = cfg_data[Q_W-1:0];
                REG_RESET_VOLT: cfg_next.reset_voltage     = cfg_data[Q_W-1:0];
                REG_REFRACT:    cfg_next.refractory_steps  = cfg_data[CNT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_coefficient <= DECAY_RESET;
            cfg_reg.input_coefficient <= '0;
            cfg_reg.bias_current      <= '0;
            cfg_reg.noise_gain        <= '0;
            cfg_reg.fire_threshold    <= '0;
            cfg_reg.reset_voltage     <= '0;
            cfg_reg.refractory_steps  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/lnu_pipe.sv */
// Six-stage neuron update pipeline with state read, hazard interlock and write-back.
module lnu_pipe #(
    parameter int NEURON_COUNT = lnu_pkg::NEURON_COUNT_DEF,
    localparam int AddrW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lnu_pkg::cfg_t                     cfg,
    input  logic                              hold,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lnu_pkg::IDX_W-1:0]         neuron_index,
    input  logic signed [lnu_pkg::Q_W-1:0]    synaptic_input,
    input  logic signed [lnu_pkg::Q_W-1:0]    noise_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lnu_pkg::IDX_W-1:0]         result_index,
    output logic                              fired,
    output logic                              in_refractory,
    output logic signed [lnu_pkg::Q_W-1:0]    membrane_voltage,
    output logic                              rd_en,
    output logic [AddrW-1:0]                  rd_addr,
    input  logic [lnu_pkg::Q_W-1:0]           rd_voltage,
    input  logic [lnu_pkg::CNT_W-1:0]         rd_count,
    output logic                              wr_en,
    output logic [AddrW-1:0]                  wr_addr,
    output logic [lnu_pkg::Q_W-1:0]           wr_voltage,
    output logic [lnu_pkg::CNT_W-1:0]         wr_count
);

    import lnu_pkg::*;

    localparam int IdxExtW = IDX_W + AddrW;

    logic en;
    logic accept;
    logic hazard;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic out_valid_reg;

    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_ok_reg;
    logic signed [Q_W-1:0] s1_syn_reg;
    logic signed [Q_W-1:0] s1_noise_reg;
    logic                  s1_ok_next;

    stage_ctl_t s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg, s6_ctl_reg;
    stage_ctl_t s2_ctl_next;

    logic signed [Q_W-1:0]    s2_sum_a_reg;
    logic signed [PROD_W-1:0] s2_prod_n_reg, s2_prod_v_reg;
    logic signed [Q_W-1:0]    s2_sum_a_next;
    logic signed [PROD_W-1:0] s2_prod_n_next, s2_prod_v_next;

    logic signed [Q_W-1:0] s3_sum_a_reg, s3_qn_reg, s3_qv_reg;
    logic signed [Q_W-1:0] s3_qn_next, s3_qv_next;

    logic signed [Q_W-1:0] s4_sum_b_reg, s4_qv_reg;
    logic signed [Q_W-1:0] s4_sum_b_next;

    logic signed [PROD_W-1:0] s5_prod_i_reg;
    logic signed [PROD_W-1:0] s5_prod_i_next;
    logic signed [Q_W-1:0]    s5_qv_reg;

    logic signed [Q_W-1:0] s6_qi_reg, s6_qv_reg;
    logic signed [Q_W-1:0] s6_qi_next;

    logic signed [Q_W-1:0] v_int;
    logic signed [Q_W-1:0] v_new;

    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_fired_reg;
    logic                  out_refr_reg;
    logic signed [Q_W-1:0] out_v_reg;

    logic [IdxExtW-1:0] in_idx_ext;
    logic [IdxExtW-1:0] s6_idx_ext;

    logic signed [Q_W-1:0] rd_v;

    // Global advance: the whole pipe freezes while a finished beat waits.
    assign en     = !out_valid_reg || !out_stall;
    assign hazard = (s1_valid_reg && s1_idx_reg == neuron_index)
                 || (s2_valid_reg && s2_ctl_reg.idx == neuron_index)
                 || (s3_valid_reg && s3_ctl_reg.idx == neuron_index)
                 || (s4_valid_reg && s4_ctl_reg.idx == neuron_index)
                 || (s5_valid_reg && s5_ctl_reg.idx == neuron_index)
                 || (s6_valid_reg && s6_ctl_reg.idx == neuron_index);
    assign in_stall = hold || !en || hazard;
    assign accept   = in_valid && !in_stall;

    assign in_idx_ext = IdxExtW'(neuron_index);
    assign s6_idx_ext = IdxExtW'(s6_ctl_reg.idx);
    assign rd_en      = accept;
    assign rd_addr    = in_idx_ext[AddrW-1:0];
    assign s1_ok_next = 32'(neuron_index) < 32'(NEURON_COUNT);
    assign rd_v       = rd_voltage;

    // Stage 1: classify the step, start both Q16.16 products.
    always_comb
    begin
        s2_ctl_next.idx   = s1_idx_reg;
        s2_ctl_next.ok    = s1_ok_reg;
        s2_ctl_next.refr  = s1_ok_reg && (rd_count != '0);
        s2_ctl_next.fire  = s1_ok_reg && (rd_count == '0) && (rd_v >= cfg.fire_threshold);
        s2_ctl_next.integ = s1_ok_reg && !s2_ctl_next.refr && !s2_ctl_next.fire;
        s2_ctl_next.fix_v = s2_ctl_next.refr ? rd_v : cfg.reset_voltage;
        if (s2_ctl_next.refr)
        begin
            s2_ctl_next.ncnt = rd_count - CNT_W'(1);
        end
        else if (s2_ctl_next.fire)
        begin
            s2_ctl_next.ncnt = cfg.refractory_steps;
        end
        else
        begin
            s2_ctl_next.ncnt = rd_count;
        end
        s2_sum_a_next  = sat_add(s1_syn_reg, cfg.bias_current);
        s2_prod_n_next = s1_noise_reg * cfg.noise_gain;
        s2_prod_v_next = cfg.decay_coefficient * rd_v;
    end

    assign s3_qn_next     = round_sat(s2_prod_n_reg);
    assign s3_qv_next     = round_sat(s2_prod_v_reg);
    assign s4_sum_b_next  = sat_add(s3_sum_a_reg, s3_qn_reg);
    assign s5_prod_i_next = cfg.input_coefficient * s4_sum_b_reg;
    assign s6_qi_next     = round_sat(s5_prod_i_reg);
    assign v_int          = sat_add(s6_qv_reg, s6_qi_reg);
    assign v_new          = s6_ctl_reg.integ ? v_int : s6_ctl_reg.fix_v;

    assign wr_en      = en && s6_valid_reg && s6_ctl_reg.ok;
    assign wr_addr    = s6_idx_ext[AddrW-1:0];
    assign wr_voltage = v_new;
    assign wr_count   = s6_ctl_reg.ncnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg    <= neuron_index;
            s1_ok_reg     <= s1_ok_next;
            s1_syn_reg    <= synaptic_input;
            s1_noise_reg  <= noise_sample;

            s2_ctl_reg    <= s2_ctl_next;
            s2_sum_a_reg  <= s2_sum_a_next;
            s2_prod_n_reg <= s2_prod_n_next;
            s2_prod_v_reg <= s2_prod_v_next;

            s3_ctl_reg    <= s2_ctl_reg;
            s3_sum_a_reg  <= s2_sum_a_reg;
            s3_qn_reg     <= s3_qn_next;
            s3_qv_reg     <= s3_qv_next;

            s4_ctl_reg    <= s3_ctl_reg;
            s4_sum_b_reg  <= s4_sum_b_next;
            s4_qv_reg     <= s3_qv_reg;

            s5_ctl_reg    <= s4_ctl_reg;
            s5_prod_i_reg <= s5_prod_i_next;
            s5_qv_reg     <= s4_qv_reg;

            s6_ctl_reg    <= s5_ctl_reg;
            s6_qi_reg     <= s6_qi_next;
            s6_qv_reg     <= s5_qv_reg;

            out_idx_reg   <= s6_ctl_reg.idx;
            out_fired_reg <= s6_ctl_reg.fire;
            out_refr_reg  <= s6_ctl_reg.refr;
            out_v_reg     <= s6_ctl_reg.ok ? v_new : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_index     = out_idx_reg;
    assign fired            = out_fired_reg;
    assign in_refractory    = out_refr_reg;
    assign membrane_voltage = out_v_reg;

endmodule

/* rtl/lif_neuron_update.sv */
// Top level of the leaky integrate-and-fire neuron update block.
//
// Input channel (in_valid / in_stall): one beat names a neuron and carries its
// synaptic current and a noise sample. Output channel (out_valid / out_stall):
// one beat per input beat, in order, with the neuron's new membrane voltage and
// its fired and refractory flags. cfg_valid / cfg_ready writes the shared
// parameter registers; cfg_ready is always high, write only while idle.
//
// An accepted beat passes through the stage registers and the output register
// to the output port. Throughput is one beat per cycle while nothing stalls the
// input. A beat whose neuron is still in flight in the six-stage pipe waits at
// the input until that neuron's write-back is done.
//
// After reset the voltage and refractory memories are swept to zero, one entry
// a cycle, over all NEURON_COUNT entries; in_stall is high during the sweep.
// When the receiver stalls a waiting output beat, the output register and the
// whole pipe hold and in_stall rises; nothing is dropped or repeated.
module lif_neuron_update #(
    parameter int NEURON_COUNT = lnu_pkg::NEURON_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lnu_pkg::IDX_W-1:0]         neuron_index,
    input  logic signed [lnu_pkg::Q_W-1:0]    synaptic_input,
    input  logic signed [lnu_pkg::Q_W-1:0]    noise_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lnu_pkg::IDX_W-1:0]         result_index,
    output logic                              fired,
    output logic                              in_refractory,
    output logic signed [lnu_pkg::Q_W-1:0]    membrane_voltage,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lnu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lnu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import lnu_pkg::*;

    localparam int AddrW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;

    cfg_t cfg;

    logic             clr_active_reg;
    logic             clr_active_next;
    logic [AddrW-1:0] clr_addr_reg;
    logic [AddrW-1:0] clr_addr_next;

    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic [Q_W-1:0]   rd_voltage;
    logic [CNT_W-1:0] rd_count;
    logic             pipe_wr_en;
    logic [AddrW-1:0] pipe_wr_addr;
    logic [Q_W-1:0]   pipe_wr_voltage;
    logic [CNT_W-1:0] pipe_wr_count;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [Q_W-1:0]   ram_wvoltage;
    logic [CNT_W-1:0] ram_wcount;

    lnu_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sweep both memories to zero after reset.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == AddrW'(NEURON_COUNT - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AddrW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    assign ram_we       = clr_active_reg || pipe_wr_en;
    assign ram_waddr    = clr_active_reg ? clr_addr_reg : pipe_wr_addr;
    assign ram_wvoltage = clr_active_reg ? '0 : pipe_wr_voltage;
    assign ram_wcount   = clr_active_reg ? '0 : pipe_wr_count;

    lnu_ram #(
        .WIDTH (Q_W),
        .DEPTH (NEURON_COUNT)
    ) u_voltage_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wvoltage),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_voltage)
    );

    lnu_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NEURON_COUNT)
    ) u_refract_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wcount),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_count)
    );

    lnu_pipe #(
        .NEURON_COUNT (NEURON_COUNT)
    ) u_pipe (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .hold             (clr_active_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .neuron_index     (neuron_index),
        .synaptic_input   (synaptic_input),
        .noise_sample     (noise_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_index     (result_index),
        .fired            (fired),
        .in_refractory    (in_refractory),
        .membrane_voltage (membrane_voltage),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_voltage       (rd_voltage),
        .rd_count         (rd_count),
        .wr_en            (pipe_wr_en),
        .wr_addr          (pipe_wr_addr),
        .wr_voltage       (pipe_wr_voltage),
        .wr_count         (pipe_wr_count)
    );

endmodule

/* rtl/lnu_checker.sv */
// Port-level assertions for the neuron update block and their bind.
module lnu_checker #(
    parameter int NEURON_COUNT = lnu_pkg::NEURON_COUNT_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [lnu_pkg::IDX_W-1:0]         neuron_index,
    input logic signed [lnu_pkg::Q_W-1:0]    synaptic_input,
    input logic signed [lnu_pkg::Q_W-1:0]    noise_sample,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [lnu_pkg::IDX_W-1:0]         result_index,
    input logic                              fired,
    input logic                              in_refractory,
    input logic signed [lnu_pkg::Q_W-1:0]    membrane_voltage,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [lnu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [lnu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_index) && $stable(fired)
            && $stable(in_refractory) && $stable(membrane_voltage))
        else $error("output beat changed while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fired && in_refractory))
        else $error("fired and in_refractory both set");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(result_index) >= 32'(NEURON_COUNT))
            |-> !fired && !in_refractory && (membrane_voltage == '0))
        else $error("out-of-range neuron produced nonzero result");

    a_same_neuron_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_valid && !in_stall) && in_valid && (neuron_index == $past(neuron_index))
            |-> in_stall)
        else $error("same neuron accepted on consecutive cycles");

endmodule

bind lif_neuron_update lnu_checker #(.NEURON_COUNT(NEURON_COUNT)) u_lnu_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for lif_neuron_update: directed table, then random phases.
module tb;
    import lnu_pkg::*;

    localparam int NEURON_TOTAL   = NEURON_COUNT_DEF;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_ITEMS    = 133;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [Q_W-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [Q_W-1:0] Q_HALF    = 32'sh0000_8000;

    typedef enum bit {ROW_WRITE, ROW_STEP} row_kind_t;
    typedef enum bit {SET_TYPICAL, SET_EXTREME} setting_kind_t;

    typedef struct {
        logic [IDX_W-1:0]      idx;
        logic                  fired;
        logic                  refr;
        logic signed [Q_W-1:0] volt;
    } step_result_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_sel;
        logic [CFG_DATA_W-1:0]   data;
        logic [IDX_W-1:0]        idx;
        logic signed [Q_W-1:0]   syn;
        logic signed [Q_W-1:0]   noise;
        bit                      typed;
        step_result_t            want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [IDX_W-1:0]      neuron_index;
    logic signed [Q_W-1:0] synaptic_input;
    logic signed [Q_W-1:0] noise_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [IDX_W-1:0]      result_index;
    logic                  fired;
    logic                  in_refractory;
    logic signed [Q_W-1:0] membrane_voltage;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic signed [Q_W-1:0] model_volt [NEURON_TOTAL];
    logic [CNT_W-1:0]      model_count [NEURON_TOTAL];
    cfg_t                  model_cfg;

    step_result_t pending_results [$];
    plan_row_t    directed_plan [$];
    int           mismatch_count = 0;
    int           quiet_left = 0;

    setting_kind_t phase_plan [7] = '{SET_TYPICAL, SET_TYPICAL, SET_EXTREME, SET_TYPICAL,
                                      SET_EXTREME, SET_TYPICAL, SET_TYPICAL};

    lif_neuron_update u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .neuron_index     (neuron_index),
        .synaptic_input   (synaptic_input),
        .noise_sample     (noise_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_index     (result_index),
        .fired            (fired),
        .in_refractory    (in_refractory),
        .membrane_voltage (membrane_voltage),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic signed [Q_W-1:0] q_clamp(input longint x);
        if (x > longint'(Q_MAX))
        begin
            return Q_MAX;
        end
        if (x < longint'(Q_MIN))
        begin
            return Q_MIN;
        end
        return x[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] q_add(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        return q_clamp(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [Q_W-1:0] q_mul(
        input logic signed [Q_W-1:0] a,
        input logic signed [Q_W-1:0] b
    );
        longint prod;
        prod = longint'(a) * longint'(b) + 64'sd32768;
        return q_clamp(prod >>> FRAC_W);
    endfunction

    function automatic step_result_t advance_neuron(
        input logic [IDX_W-1:0]      idx,
        input logic signed [Q_W-1:0] syn,
        input logic signed [Q_W-1:0] noise
    );
        step_result_t          res;
        logic signed [Q_W-1:0] volt;
        logic signed [Q_W-1:0] drive;
        res.idx   = idx;
        res.fired = 1'b0;
        res.refr  = 1'b0;
        res.volt  = '0;
        if (idx < NEURON_TOTAL)
        begin
            volt = model_volt[idx];
            if (model_count[idx] != '0)
            begin
                model_count[idx] = model_count[idx] - CNT_W'(1);
                res.refr = 1'b1;
            end
            else if ($signed(volt) >= $signed(model_cfg.fire_threshold))
            begin
                res.fired = 1'b1;
                volt = model_cfg.reset_voltage;
                model_count[idx] = model_cfg.refractory_steps;
            end
            else
            begin
                drive = q_add(syn, model_cfg.bias_current);
                drive = q_add(drive, q_mul(noise, model_cfg.noise_gain));
                volt  = q_add(q_mul(model_cfg.decay_coefficient, volt),
                              q_mul(model_cfg.input_coefficient, drive));
            end
            model_volt[idx] = volt;
            res.volt = volt;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] extreme_q();
        case ($urandom_range(0, 6))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return '1;
            4:       return 32'd1;
            5:       return Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] extreme_count();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_step(
        input logic [IDX_W-1:0]      idx,
        input logic signed [Q_W-1:0] syn,
        input logic signed [Q_W-1:0] noise
    );
        plan_row_t row;
        row.kind  = ROW_STEP;
        row.idx   = idx;
        row.syn   = syn;
        row.noise = noise;
        row.typed = 1'b0;
        directed_plan.push_back(row);
    endtask

    task automatic add_checked(
        input logic [IDX_W-1:0]      idx,
        input logic signed [Q_W-1:0] syn,
        input logic signed [Q_W-1:0] noise,
        input logic                  want_fired,
        input logic                  want_refr,
        input logic signed [Q_W-1:0] want_volt
    );
        plan_row_t row;
        row.kind       = ROW_STEP;
        row.idx        = idx;
        row.syn        = syn;
        row.noise      = noise;
        row.typed      = 1'b1;
        row.want.idx   = idx;
        row.want.fired = want_fired;
        row.want.refr  = want_refr;
        row.want.volt  = want_volt;
        directed_plan.push_back(row);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.kind    = ROW_WRITE;
        row.reg_sel = sel;
        row.data    = data;
        directed_plan.push_back(row);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  sel,
        input logic [CFG_DATA_W-1:0] data
    );
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (sel)
            REG_DECAY_COEF: model_cfg.decay_coefficient = data;
            REG_INPUT_COEF: model_cfg.input_coefficient = data;
            REG_BIAS:       model_cfg.bias_current      = data;
            REG_NOISE_GAIN: model_cfg.noise_gain        = data;
            REG_THRESHOLD:  model_cfg.fire_threshold    = data;
            REG_RESET_VOLT: model_cfg.reset_voltage     = data;
            REG_REFRACT:    model_cfg.refractory_steps  = data[CNT_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_step(
        input logic [IDX_W-1:0]      idx,
        input logic signed [Q_W-1:0] syn,
        input logic signed [Q_W-1:0] noise,
        input bit                    typed,
        input step_result_t          want
    );
        step_result_t predicted;
        int           gap;
        @(negedge clk);
        in_valid       <= 1'b1;
        neuron_index   <= idx;
        synaptic_input <= syn;
        noise_sample   <= noise;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted = advance_neuron(idx, syn, noise);
        pending_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic apply_setting(input setting_kind_t kind);
        wait_drained();
        if (kind == SET_TYPICAL)
        begin
            write_register(REG_DECAY_COEF, 32'($urandom_range(52429, 65536)));
            write_register(REG_INPUT_COEF, 32'($urandom_range(6554, 65536)));
            write_register(REG_BIAS, 32'(int'($urandom_range(0, 32768)) - 16384));
            write_register(REG_NOISE_GAIN, 32'($urandom_range(0, 26214)));
            write_register(REG_THRESHOLD, 32'($urandom_range(32768, 131072)));
            write_register(REG_RESET_VOLT, 32'(-int'($urandom_range(0, 65536))));
            write_register(REG_REFRACT, {16'($urandom), 16'($urandom_range(0, 5))});
        end
        else
        begin
            write_register(REG_DECAY_COEF, extreme_q());
            write_register(REG_INPUT_COEF, extreme_q());
            write_register(REG_BIAS, extreme_q());
            write_register(REG_NOISE_GAIN, extreme_q());
            write_register(REG_THRESHOLD, extreme_q());
            write_register(REG_RESET_VOLT, extreme_q());
            write_register(REG_REFRACT, {16'($urandom), extreme_count()});
        end
        write_register(REG_UNUSED, $urandom);
    endtask

    task automatic run_phase(input setting_kind_t kind);
        logic [IDX_W-1:0]      base;
        logic [IDX_W-1:0]      idx;
        logic signed [Q_W-1:0] syn;
        logic signed [Q_W-1:0] noise;
        step_result_t          unused_want;
        int                    r;
        apply_setting(kind);
        base = IDX_W'($urandom);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                idx = IDX_W'(base + $urandom_range(0, 7));
            else if (r < 80)
                idx = r[0] ? '1 : '0;
            else
                idx = IDX_W'($urandom);
            if ($urandom_range(0, 9) < 8)
                syn = 32'(int'($urandom_range(0, 163840)) - 32768);
            else
                syn = $urandom;
            if ($urandom_range(0, 9) < 8)
                noise = 32'(int'($urandom_range(0, 131072)) - 65536);
            else
                noise = $urandom;
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            send_step(idx, syn, noise, 1'b0, unused_want);
        end
    endtask

    initial
    begin
        int run;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            r_stretch: begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 70)
                    run = $urandom_range(1, 8);
                else if (r < 95)
                    run = $urandom_range(9, 40);
                else
                    run = $urandom_range(100, 300);
                r = $urandom_range(0, 99);
                if (r < 80)
                    hold = $urandom_range(1, 3);
                else if (r < 97)
                    hold = $urandom_range(4, 12);
                else
                    hold = $urandom_range(20, 60);
            end
            repeat (run) @(negedge clk) out_stall <= 1'b0;
            repeat (hold) @(negedge clk) out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        step_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: idx=%0d fired=%0b refr=%0b v=%0d",
                             result_index, fired, in_refractory, membrane_voltage);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_index !== want.idx || fired !== want.fired ||
                    in_refractory !== want.refr || membrane_voltage !== want.volt)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result mismatch: expected idx=%0d fired=%0b refr=%0b v=%0d, %s",
                                 want.idx, want.fired, want.refr, want.volt,
                                 $sformatf("got idx=%0d fired=%0b refr=%0b v=%0d",
                                           result_index, fired, in_refractory,
                                           membrane_voltage));
                end
            end
        end
    end

    initial
    begin
        plan_row_t row;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        neuron_index   = '0;
        synaptic_input = '0;
        noise_sample   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;

        model_cfg                   = '0;
        model_cfg.decay_coefficient = DECAY_RESET;
        for (int i = 0; i < NEURON_TOTAL; i++)
        begin
            model_volt[i]  = '0;
            model_count[i] = '0;
        end

        // after reset every neuron sits at threshold and fires
        add_checked(10'd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 32'sd0);
        add_checked(10'd1023, Q_MAX, Q_MIN, 1'b1, 1'b0, 32'sd0);
        add_checked(10'd0, Q_MIN, Q_MAX, 1'b1, 1'b0, 32'sd0);
        add_write(REG_INPUT_COEF, Q_ONE);
        add_write(REG_THRESHOLD, Q_MAX);
        add_write(REG_RESET_VOLT, Q_MIN);
        add_write(REG_REFRACT, 32'd2);
        add_checked(10'd5, Q_MAX, 32'sd0, 1'b0, 1'b0, Q_MAX);
        add_checked(10'd5, 32'sd0, 32'sd0, 1'b1, 1'b0, Q_MIN);
        add_checked(10'd5, Q_MAX, Q_MAX, 1'b0, 1'b1, Q_MIN);
        add_checked(10'd5, Q_MIN, Q_MIN, 1'b0, 1'b1, Q_MIN);
        add_checked(10'd5, Q_MIN, Q_MAX, 1'b0, 1'b0, Q_MIN);
        add_checked(10'd6, -32'sd1, 32'sd0, 1'b0, 1'b0, -32'sd1);
        add_write(REG_DECAY_COEF, Q_MIN);
        add_write(REG_INPUT_COEF, Q_MAX);
        add_write(REG_BIAS, Q_MAX);
        add_write(REG_NOISE_GAIN, Q_MIN);
        add_step(10'd7, Q_MIN, Q_MIN);
        add_step(10'd7, Q_MAX, Q_MAX);
        add_step(10'd6, 32'sd0, 32'sd1);
        add_step(10'd1023, 32'sh5A5A_A5A5, 32'shA5A5_5A5A);
        add_write(REG_THRESHOLD, Q_MIN);
        add_write(REG_RESET_VOLT, Q_MAX);
        add_write(REG_REFRACT, 32'hABCD_FFFF);
        add_checked(10'd8, 32'sd0, 32'sd0, 1'b1, 1'b0, Q_MAX);
        add_checked(10'd8, 32'sd0, 32'sd0, 1'b0, 1'b1, Q_MAX);
        add_checked(10'd9, Q_MIN, Q_MIN, 1'b1, 1'b0, Q_MAX);
        // out-of-range register index must leave the threshold alone
        add_write(REG_UNUSED, 32'hFFFF_FFFF);
        add_checked(10'd10, 32'sd0, 32'sd0, 1'b1, 1'b0, Q_MAX);
        add_write(REG_DECAY_COEF, Q_HALF);
        add_write(REG_THRESHOLD, Q_MAX);
        add_step(10'd6, 32'sd3, -32'sd3);
        add_step(10'd6, 32'sd65537, 32'sd99);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_drained();
                write_register(row.reg_sel, row.data);
            end
            else
            begin
                send_step(row.idx, row.syn, row.noise, row.typed, row.want);
            end
        end

        foreach (phase_plan[p])
            run_phase(phase_plan[p]);

        wait_drained();
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
